>>> rtl/utf8d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants of the UTF-8 decoder with byte escape.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [CpW-1:0] ESCAPE_BASE = 21'h00DC00;

  localparam logic [7:0] ASCII_END   = 8'h80;
  localparam logic [7:0] LEAD2_MIN   = 8'hC2;
  localparam logic [7:0] LEAD3_MIN   = 8'hE0;
  localparam logic [7:0] LEAD4_MIN   = 8'hF0;
  localparam logic [7:0] LEAD4_MAX   = 8'hF4;
  localparam logic [7:0] LEAD_END    = 8'hF5;
  localparam logic [7:0] E0_SEC_MIN  = 8'hA0;
  localparam logic [7:0] F0_SEC_MIN  = 8'h90;
  localparam logic [7:0] F4_SEC_END  = 8'h90;

  // Per-byte classification produced by the front end
  typedef struct packed {
    logic [7:0] data;
    logic [2:0] len;   // sequence length if used as a lead, 0 if not a lead
    logic       cont;  // matches 10xxxxxx
  } byte_info_t;

  // One queued word
  typedef struct packed {
    byte_info_t info;
    logic       last_in;
  } word_t;

endpackage

>>> rtl/utf8_decoder_with_byte_escape_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_decoder_with_byte_escape_top
// UTF-8 to code points; bytes opening no valid sequence escaped as DC00+byte.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i/in_ready_o) takes one raw byte per word plus
//    stream_end_i, which flushes any bytes still held.
//  - Output channel (out_valid_o/out_ready_i) gives one code point per word;
//    last_of_run_o marks the final result caused by an input byte. A byte
//    that only extends an unfinished sequence gives no result.
//  - A byte accepted into an empty queue is written there at the accepting
//    edge; the scan step then loads its result from the queue into the
//    output register, which presents it on code_point_o.
//  - Throughput: one scan step per cycle while the output is not stalled.
//    A byte gives at most one result per step; a byte that triggers rescans
//    after an error gives one per step, up to four results, and the scanner
//    takes no new byte meanwhile; the single scan step sets this rate.
//  - The front queue (QueueDepth words) keeps taking bytes while the scanner
//    works through rescans or the output is stalled.
//  - Stall: when out_ready_i is low the output register holds its word and
//    the scanner waits; the queue fills and in_ready_o then drops.
//  - Reset (rst_ni low, async) empties the queue, drops held bytes and
//    clears the output valid.
// ----------------------------------------------------------------------------
module utf8_decoder_with_byte_escape_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                byte_in_i,
  input  logic                      stream_end_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [utf8d_pkg::CpW-1:0] code_point_o,
  output logic                      last_of_run_o
);
  import utf8d_pkg::*;

  // classified byte queue between front and scanner
  word_t q_word;
  logic  q_valid, q_ready;

  utf8d_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .byte_in_i    (byte_in_i),
    .stream_end_i (stream_end_i),
    .q_valid_o    (q_valid),
    .q_ready_i    (q_ready),
    .q_word_o     (q_word)
  );

  // scanner: held window, at most one result per step, output register
  utf8d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_ready_o     (q_ready),
    .q_word_i      (q_word),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .code_point_o  (code_point_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

>>> rtl/utf8d_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_front
// Accepts raw bytes, classifies them and queues them for the scanner.
// ----------------------------------------------------------------------------
module utf8d_front #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       byte_in_i,
  input  logic             stream_end_i,
  output logic             q_valid_o,
  input  logic             q_ready_i,
  output utf8d_pkg::word_t q_word_o
);
  import utf8d_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  word_t             mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   fill_q, fill_d;
  logic              push, pop;
  word_t             word_new;

  // classify the incoming byte
  always_comb begin
    word_new.info.data = byte_in_i;
    word_new.info.cont = (byte_in_i[7:6] == 2'b10);
    word_new.last_in   = stream_end_i;
    if (byte_in_i < ASCII_END) begin
      word_new.info.len = 3'd1;
    end else if (byte_in_i < LEAD2_MIN) begin
      word_new.info.len = 3'd0;
    end else if (byte_in_i < LEAD3_MIN) begin
      word_new.info.len = 3'd2;
    end else if (byte_in_i < LEAD4_MIN) begin
      word_new.info.len = 3'd3;
    end else if (byte_in_i < LEAD_END) begin
      word_new.info.len = 3'd4;
    end else begin
      word_new.info.len = 3'd0;
    end
  end

  assign in_ready_o = (fill_q != CntW'(Depth));
  assign q_valid_o  = (fill_q != '0);
  assign q_word_o   = mem_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= word_new;
    end
  end

endmodule

>>> rtl/utf8d_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_back
// Held-window scanner: at most one code point or escape per unstalled cycle.
// ----------------------------------------------------------------------------
module utf8d_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  output logic                      q_ready_o,
  input  utf8d_pkg::word_t          q_word_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [utf8d_pkg::CpW-1:0] code_point_o,
  output logic                      last_of_run_o
);
  import utf8d_pkg::*;

  typedef byte_info_t [3:0] window_t;

  typedef struct packed {
    logic       hold;
    logic       bad;
    logic [2:0] consume;
  } scan_t;

  function automatic logic follower_ok(logic [7:0] lead, int unsigned idx, byte_info_t b);
    logic ok;
    ok = b.cont;
    if (idx == 1) begin
      if (lead == LEAD3_MIN && b.data < E0_SEC_MIN) ok = 1'b0;
      if (lead == LEAD4_MIN && b.data < F0_SEC_MIN) ok = 1'b0;
      if (lead == LEAD4_MAX && b.data >= F4_SEC_END) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic scan_t scan(window_t w, logic [2:0] n, logic fin);
    scan_t      s;
    logic [2:0] need;
    logic       short_seq;
    need  = w[0].len;
    s.bad = (need == 3'd0);
    for (int unsigned i = 1; i < 4; i++) begin
      if (3'(i) < need && 3'(i) < n && !follower_ok(w[0].data, i, w[i])) begin
        s.bad = 1'b1;
      end
    end
    short_seq = !s.bad && (n < need);
    s.hold    = short_seq && !fin && (n != 3'd0);
    if (short_seq && fin) s.bad = 1'b1;
    s.consume = s.bad ? 3'd1 : need;
    return s;
  endfunction

  window_t          buf_q, buf_d, win, shifted;
  logic [2:0]       cnt_q, cnt_d, win_n, rem;
  logic             end_q, end_d, win_end;
  logic             busy_q, busy_d;
  logic             out_valid_q, out_valid_d;
  logic [CpW-1:0]   code_q, code_d, cp;
  logic             last_q, last_d, last;
  logic             out_free, fire;
  scan_t            cur, nxt;

  assign out_free  = !out_valid_q || out_ready_i;
  assign q_ready_o = !busy_q && out_free;
  assign fire      = out_free && (busy_q || q_valid_i);

  // working window: held state, plus the new byte when starting a fresh word
  always_comb begin
    win     = buf_q;
    win_n   = cnt_q;
    win_end = end_q;
    if (!busy_q) begin
      win[cnt_q[1:0]] = q_word_i.info;
      win_n           = cnt_q + 3'd1;
      win_end         = q_word_i.last_in;
    end
  end

  always_comb begin
    int unsigned idx;
    cur = scan(win, win_n, win_end);
    rem = win_n - cur.consume;
    for (int unsigned j = 0; j < 4; j++) begin
      idx = j + 32'(cur.consume);
      shifted[j] = (idx < 4) ? win[idx[1:0]] : '0;
    end
    nxt  = scan(shifted, rem, win_end);
    last = (rem == 3'd0) || nxt.hold;
    if (cur.bad) begin
      cp = ESCAPE_BASE + CpW'(win[0].data);
    end else begin
      case (win[0].len)
        3'd2:    cp = CpW'({win[0].data[4:0], win[1].data[5:0]});
        3'd3:    cp = CpW'({win[0].data[3:0], win[1].data[5:0], win[2].data[5:0]});
        3'd4:    cp = {win[0].data[2:0], win[1].data[5:0], win[2].data[5:0],
                       win[3].data[5:0]};
        default: cp = CpW'(win[0].data);
      endcase
    end
  end

  always_comb begin
    buf_d       = buf_q;
    cnt_d       = cnt_q;
    end_d       = end_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q && !out_ready_i;
    code_d      = code_q;
    last_d      = last_q;
    if (fire) begin
      end_d = win_end;
      if (cur.hold) begin
        buf_d  = win;
        cnt_d  = win_n;
        busy_d = 1'b0;
      end else begin
        buf_d       = shifted;
        cnt_d       = rem;
        busy_d      = !last;
        out_valid_d = 1'b1;
        code_d      = cp;
        last_d      = last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      end_q       <= 1'b0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      end_q       <= end_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q  <= buf_d;
    code_q <= code_d;
    last_q <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign code_point_o  = code_q;
  assign last_of_run_o = last_q;

  a_busy_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q != 3'd0))
    else $error("scanner busy with empty window");

  a_idle_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (cnt_q <= 3'd3))
    else $error("idle scanner holds more than three bytes");

  a_flushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_q && end_q) |-> (cnt_q == 3'd0))
    else $error("bytes left held after stream end");

  a_emit_on_continue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && busy_q) |=> out_valid_q)
    else $error("continued scan step produced no result");

endmodule
